// ----- hw/rtl/midi_voice_allocator_unit_defines.svh -----
// assertion macros for the midi voice allocator
// used by the top level, which provides clk and rst_n
`ifndef MIDI_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`define MIDI_VOICE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MVA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MVA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/mva_pkg.sv -----
// shared types and codes of the midi voice allocator
// no dependencies
package mva_pkg;

  localparam int MAX_RESULTS = 5;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_OTHER    = 2'd2,
    OP_TOGGLE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ON_VEL  = 2'd0,
    KIND_ON_KEEP = 2'd1,
    KIND_OFF     = 2'd2,
    KIND_LED     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LRN_PREV,
    ST_LRN_JOIN,
    ST_OFFS,
    ST_LED
  } state_t;

  // step strobes from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    logic search;
    logic lrn_prev;
    logic lrn_join;
    logic offs;
    logic led;
    logic off_last;
  } ctl_t;

  // verdict of the voice compare unit for one voice
  typedef struct packed {
    logic       hit;
    logic [1:0] active_nxt;
    logic       wr_first;
    logic       wr_second;
    kind_t      kind;
    logic [6:0] pitch;
  } match_t;

endpackage

// ----- hw/rtl/mva_match.sv -----
// voice compare unit: decides how one voice handles a note request
// depends on mva_pkg
module mva_match (
  input  logic [1:0]      op,
  input  logic [3:0]      channel,
  input  logic [6:0]      note,
  input  logic            mono,
  input  logic [3:0]      voice_channel,
  input  logic [6:0]      first_note,
  input  logic [6:0]      second_note,
  input  logic [1:0]      active,
  output mva_pkg::match_t res
);

  logic is_on;
  logic is_off;
  logic [1:0] left;

  assign is_on  = (mva_pkg::opcode_t'(op) == mva_pkg::OP_NOTE_ON);
  assign is_off = (mva_pkg::opcode_t'(op) == mva_pkg::OP_NOTE_OFF);

  always_comb begin
    res            = '0;
    res.active_nxt = active;
    res.kind       = mva_pkg::KIND_OFF;
    left           = '0;
    if (voice_channel == channel) begin
      if (mono) begin
        if (is_on) begin
          if (!active[0]) begin
            res.hit        = 1'b1;
            res.wr_first   = 1'b1;
            res.active_nxt = active | 2'b01;
            res.kind       = mva_pkg::KIND_ON_VEL;
            res.pitch      = note;
          end else if (!active[1]) begin
            res.hit        = 1'b1;
            res.wr_second  = 1'b1;
            res.active_nxt = active | 2'b10;
            res.kind       = mva_pkg::KIND_ON_VEL;
            res.pitch      = note;
          end
        end else if (is_off) begin
          // match ignores the active bits, first note wins
          if (note == first_note) begin
            left           = active & 2'b10;
            res.hit        = 1'b1;
            res.active_nxt = left;
            res.kind       = (left == 2'b00) ? mva_pkg::KIND_OFF : mva_pkg::KIND_ON_KEEP;
            res.pitch      = second_note;
          end else if (note == second_note) begin
            left           = active & 2'b01;
            res.hit        = 1'b1;
            res.active_nxt = left;
            res.kind       = (left == 2'b00) ? mva_pkg::KIND_OFF : mva_pkg::KIND_ON_KEEP;
            res.pitch      = first_note;
          end
        end
      end else begin
        if (is_on && active == 2'b00) begin
          res.hit        = 1'b1;
          res.wr_first   = 1'b1;
          res.active_nxt = 2'b01;
          res.kind       = mva_pkg::KIND_ON_VEL;
          res.pitch      = note;
        end else if (is_off && active == 2'b01 && note == first_note) begin
          res.hit        = 1'b1;
          res.active_nxt = 2'b00;
          res.kind       = mva_pkg::KIND_OFF;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/mva_ctrl.sv -----
// sequencer of the voice allocator: steps the voice index and the learn steps
// depends on mva_pkg
module mva_ctrl #(
  parameter int VOICES = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           opcode,
  input  logic                 ch_ok,
  input  logic                 learning,
  input  logic                 hit,
  output logic                 busy,
  output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] vidx,
  output mva_pkg::ctl_t        ctl
);

  localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NOFF = (VOICES < mva_pkg::MAX_RESULTS) ? VOICES : mva_pkg::MAX_RESULTS;
  localparam bit LED_AFTER_OFFS = (VOICES < mva_pkg::MAX_RESULTS);

  mva_pkg::state_t state_r, state_nxt;
  logic [VW-1:0]   vidx_r, vidx_nxt;
  mva_pkg::opcode_t op;
  logic at_last_voice;
  logic at_last_off;

  assign op            = mva_pkg::opcode_t'(opcode);
  assign at_last_voice = (vidx_r == VW'(VOICES - 1));
  assign at_last_off   = (vidx_r == VW'(NOFF - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mva_pkg::ST_IDLE: begin
        if (start) begin
          if (op == mva_pkg::OP_TOGGLE) begin
            state_nxt = learning ? mva_pkg::ST_LED : mva_pkg::ST_OFFS;
          end else if (learning) begin
            if (op == mva_pkg::OP_NOTE_ON && ch_ok) state_nxt = mva_pkg::ST_LRN_PREV;
          end else if ((op inside {mva_pkg::OP_NOTE_ON, mva_pkg::OP_NOTE_OFF}) && ch_ok) begin
            state_nxt = mva_pkg::ST_SEARCH;
          end
        end
      end
      mva_pkg::ST_SEARCH: begin
        if (hit || at_last_voice) state_nxt = mva_pkg::ST_IDLE;
      end
      mva_pkg::ST_LRN_PREV: state_nxt = mva_pkg::ST_LRN_JOIN;
      mva_pkg::ST_LRN_JOIN: state_nxt = mva_pkg::ST_IDLE;
      mva_pkg::ST_OFFS: begin
        if (at_last_off) state_nxt = LED_AFTER_OFFS ? mva_pkg::ST_LED : mva_pkg::ST_IDLE;
      end
      mva_pkg::ST_LED: state_nxt = mva_pkg::ST_IDLE;
      default: state_nxt = mva_pkg::ST_IDLE;
    endcase
  end

  // step strobes
  always_comb begin
    ctl          = '0;
    ctl.off_last = at_last_off;
    busy         = 1'b1;
    case (state_r)
      mva_pkg::ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      mva_pkg::ST_SEARCH:   ctl.search   = 1'b1;
      mva_pkg::ST_LRN_PREV: ctl.lrn_prev = 1'b1;
      mva_pkg::ST_LRN_JOIN: ctl.lrn_join = 1'b1;
      mva_pkg::ST_OFFS:     ctl.offs     = 1'b1;
      mva_pkg::ST_LED:      ctl.led      = 1'b1;
      default:              busy         = 1'b0;
    endcase
  end

  assign vidx_nxt = (state_r inside {mva_pkg::ST_SEARCH, mva_pkg::ST_OFFS}) ?
                    vidx_r + VW'(1) : '0;
  assign vidx     = vidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mva_pkg::ST_IDLE;
      vidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      vidx_r  <= vidx_nxt;
    end
  end

endmodule

// ----- hw/rtl/midi_voice_allocator_unit.sv -----
// top level of the midi voice allocator: voice and channel tables, result register
// depends on mva_pkg, mva_ctrl, mva_match and midi_voice_allocator_unit_defines.svh
//
// A request is taken when start is high and busy is low; busy stays high until
// the request is finished. Results come out on the out_ ports with out_strobe
// high for one cycle each and cannot be held off; out_last marks the final
// result of a request, and a request may give none. One voice compare unit
// steps through the voices one per cycle: a normal note request searches them
// until one takes it or the last is checked, a learn note-on releases the old
// channel of the learn slot and joins the new one, a toggle that leaves learn
// mode gives the LED result, and one that enters it gives a note-off for each
// of the first min(VOICES, 5) voices, then the LED result if VOICES is below 5.
// Results of one request come back to back, each registered after its step.
`include "midi_voice_allocator_unit_defines.svh"

module midi_voice_allocator_unit #(
  parameter int VOICES   = 4,
  parameter int CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_channel,
  input  logic [6:0] in_note,
  input  logic [6:0] in_velocity,
  output logic       out_strobe,
  output logic [1:0] out_kind,
  output logic [1:0] out_voice,
  output logic [6:0] out_base_note,
  output logic [6:0] out_pitch_note,
  output logic [6:0] out_note_velocity,
  output logic       out_led_blink,
  output logic       out_last
);

  localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNW = $clog2(VOICES + 1);
  localparam bit OFF_CAPPED = (VOICES >= mva_pkg::MAX_RESULTS);

  mva_pkg::ctl_t   ctl;
  mva_pkg::match_t m;
  logic [VW-1:0]   vidx;

  // mode and tables
  logic            learning_r;
  logic [VW-1:0]   slot_r;
  logic [3:0]      vch_r    [VOICES];
  logic [6:0]      first_r  [VOICES];
  logic [6:0]      second_r [VOICES];
  logic [1:0]      active_r [VOICES];
  logic [CNW-1:0]  cnt_r    [CHANNELS];
  logic [6:0]      base_r   [CHANNELS];

  // latched request
  logic [1:0] op_r;
  logic [3:0] ch_r;
  logic [6:0] note_r;
  logic [6:0] vel_r;

  // result register
  logic       strobe_r, strobe_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [1:0] voice_r, voice_nxt;
  logic [6:0] obase_r, obase_nxt;
  logic [6:0] pitch_r, pitch_nxt;
  logic [6:0] ovel_r, ovel_nxt;
  logic       blink_r, blink_nxt;
  logic       last_r, last_nxt;

  logic            in_ch_ok;
  logic [VW-1:0]   vrd_idx;
  logic [3:0]      vch_rd;
  logic [CHW-1:0]  ch_idx;
  logic [CHW-1:0]  cnt_idx;
  logic [CNW-1:0]  cnt_rd;
  logic [6:0]      base_rd;
  logic            prev_ok;
  logic            mono;
  logic            slot_last;

  assign in_ch_ok  = ({1'b0, in_channel} < 5'(CHANNELS));
  assign vrd_idx   = (ctl.lrn_prev || ctl.lrn_join) ? slot_r : vidx;
  assign vch_rd    = vch_r[vrd_idx];
  assign ch_idx    = ch_r[CHW-1:0];
  assign prev_ok   = ({1'b0, vch_rd} < 5'(CHANNELS));
  // the old channel of the learn slot is read while it is released
  assign cnt_idx   = ctl.lrn_prev ? vch_rd[CHW-1:0] : ch_idx;
  assign cnt_rd    = cnt_r[cnt_idx];
  assign base_rd   = base_r[ch_idx];
  assign mono      = (cnt_rd == CNW'(1));
  assign slot_last = (slot_r == VW'(VOICES - 1));

  mva_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .opcode   (in_opcode),
    .ch_ok    (in_ch_ok),
    .learning (learning_r),
    .hit      (m.hit),
    .busy     (busy),
    .vidx     (vidx),
    .ctl      (ctl)
  );

  mva_match u_match (
    .op            (op_r),
    .channel       (ch_r),
    .note          (note_r),
    .mono          (mono),
    .voice_channel (vch_rd),
    .first_note    (first_r[vidx]),
    .second_note   (second_r[vidx]),
    .active        (active_r[vidx]),
    .res           (m)
  );

  // result formatting
  always_comb begin
    strobe_nxt = 1'b0;
    kind_nxt   = kind_r;
    voice_nxt  = voice_r;
    obase_nxt  = obase_r;
    pitch_nxt  = pitch_r;
    ovel_nxt   = ovel_r;
    blink_nxt  = blink_r;
    last_nxt   = last_r;
    if (ctl.search && m.hit) begin
      strobe_nxt = 1'b1;
      kind_nxt   = m.kind;
      voice_nxt  = 2'(vidx);
      obase_nxt  = (m.kind == mva_pkg::KIND_OFF) ? 7'd0 : base_rd;
      pitch_nxt  = (m.kind == mva_pkg::KIND_OFF) ? 7'd0 : m.pitch;
      ovel_nxt   = (m.kind == mva_pkg::KIND_ON_VEL) ? vel_r : 7'd0;
      blink_nxt  = 1'b0;
      last_nxt   = 1'b1;
    end else if (ctl.offs) begin
      strobe_nxt = 1'b1;
      kind_nxt   = mva_pkg::KIND_OFF;
      voice_nxt  = 2'(vidx);
      obase_nxt  = 7'd0;
      pitch_nxt  = 7'd0;
      ovel_nxt   = 7'd0;
      blink_nxt  = 1'b0;
      last_nxt   = OFF_CAPPED && ctl.off_last;
    end else if (ctl.led || (ctl.lrn_join && slot_last)) begin
      strobe_nxt = 1'b1;
      kind_nxt   = mva_pkg::KIND_LED;
      voice_nxt  = 2'd0;
      obase_nxt  = 7'd0;
      pitch_nxt  = 7'd0;
      ovel_nxt   = 7'd0;
      blink_nxt  = ctl.led ? learning_r : 1'b0;
      last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_r <= 1'b0;
      slot_r     <= '0;
      for (int v = 0; v < VOICES; v++) begin
        vch_r[v]    <= 4'd0;
        first_r[v]  <= 7'd0;
        second_r[v] <= 7'd0;
        active_r[v] <= 2'd0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_r[c]  <= (c == 0) ? CNW'(VOICES) : '0;
        base_r[c] <= 7'd0;
      end
    end else begin
      if (ctl.accept && mva_pkg::opcode_t'(in_opcode) == mva_pkg::OP_TOGGLE) begin
        learning_r <= !learning_r;
        if (!learning_r) begin
          slot_r <= '0;
          for (int v = 0; v < VOICES; v++) active_r[v] <= 2'd0;
        end
      end
      if (ctl.search && m.hit) begin
        active_r[vidx] <= m.active_nxt;
        if (m.wr_first)  first_r[vidx]  <= note_r;
        if (m.wr_second) second_r[vidx] <= note_r;
      end
      if (ctl.lrn_prev && prev_ok && cnt_rd != '0) begin
        cnt_r[cnt_idx] <= cnt_rd - CNW'(1);
      end
      if (ctl.lrn_join) begin
        vch_r[slot_r]  <= ch_r;
        base_r[ch_idx] <= note_r;
        if (cnt_rd < CNW'(VOICES)) cnt_r[ch_idx] <= cnt_rd + CNW'(1);
        if (slot_last) begin
          learning_r <= 1'b0;
          slot_r     <= '0;
        end else begin
          slot_r <= slot_r + VW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_r   <= in_opcode;
      ch_r   <= in_channel;
      note_r <= in_note;
      vel_r  <= in_velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
    kind_r  <= kind_nxt;
    voice_r <= voice_nxt;
    obase_r <= obase_nxt;
    pitch_r <= pitch_nxt;
    ovel_r  <= ovel_nxt;
    blink_r <= blink_nxt;
    last_r  <= last_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_kind          = kind_r;
  assign out_voice         = voice_r;
  assign out_base_note     = obase_r;
  assign out_pitch_note    = pitch_r;
  assign out_note_velocity = ovel_r;
  assign out_led_blink     = blink_r;
  assign out_last          = last_r;

  `MVA_ASSERT_NEXT(a_last_ends_burst, out_strobe && out_last, !out_strobe, "result after last")
  `MVA_ASSERT_NEXT(a_burst_unbroken, out_strobe && !out_last, out_strobe, "gap in result burst")
  `MVA_ASSERT_IMP(a_busy_in_burst, out_strobe && !out_last, busy, "idle before last result")
  `MVA_ASSERT_IMP(a_one_step, 1'b1, $onehot0({ctl.search, ctl.lrn_prev, ctl.lrn_join, ctl.offs, ctl.led}), "two steps at once")

endmodule
